/* hw/rtl/pira_pkg.sv */
// Shared types, sizes and codes for the positional insert/remove list.
// Used by pira_ctrl, pira_cell and positional_insert_remove_array.
package pira_pkg;

	// Number of entries the list can hold.
	localparam int CAPACITY = 16;

	// Field widths.
	localparam int FUNC_W = 2;
	localparam int POS_W = 5;
	localparam int DATA_W = 32;
	localparam int STAT_W = 2;

	// Cell index and element count widths follow from the capacity.
	localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W = $clog2(CAPACITY + 1);
	// Common width used for all position, index and count comparisons.
	localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

	// Operation codes.
	localparam logic [FUNC_W-1:0] FN_READ = 2'd0;
	localparam logic [FUNC_W-1:0] FN_INSERT = 2'd1;
	localparam logic [FUNC_W-1:0] FN_REMOVE = 2'd2;

	// Status codes.
	localparam logic [STAT_W-1:0] ST_DONE = 2'd0;
	localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
	localparam logic [STAT_W-1:0] ST_FULL = 2'd2;

	// Shift command broadcast from the controller to every cell.
	typedef struct packed {
		logic ins;
		logic rem;
		logic [CMP_W-1:0] pos;
	} cell_cmd_t;

endpackage

/* hw/rtl/pira_cell.sv */
// One storage cell of the list: holds, loads the new value, or takes its neighbor's entry.
// Depends on pira_pkg.
module pira_cell (
	input logic clk,
	input pira_pkg::cell_cmd_t cmd,
	input logic [pira_pkg::IDX_W-1:0] idx,
	input logic [pira_pkg::DATA_W-1:0] value,
	input logic [pira_pkg::DATA_W-1:0] left_data,
	input logic [pira_pkg::DATA_W-1:0] right_data,
	output logic [pira_pkg::DATA_W-1:0] data_q
);
	import pira_pkg::*;

	logic [CMP_W-1:0] idx_ext;
	logic [DATA_W-1:0] data_d;

	assign idx_ext = CMP_W'(idx);

	// Insert moves entries at and above the position up; remove moves them down.
	always_comb begin
		data_d = data_q;
		if (cmd.ins) begin
			if (idx_ext == cmd.pos) begin
				data_d = value;
			end else if (idx_ext > cmd.pos) begin
				data_d = left_data;
			end
		end else if (cmd.rem) begin
			if (idx_ext >= cmd.pos) begin
				data_d = right_data;
			end
		end
	end

	// Entry storage; contents are only meaningful below the element count.
	always_ff @(posedge clk) begin
		data_q <= data_d;
	end

endmodule

/* hw/rtl/pira_ctrl.sv */
// Request decoder and element counter: checks the position, sets the status and drives
// the shift command for the cell row. Depends on pira_pkg.
module pira_ctrl (
	input logic clk,
	input logic arst_n,
	input logic accept,
	input logic [pira_pkg::FUNC_W-1:0] func,
	input logic [pira_pkg::POS_W-1:0] position,
	output pira_pkg::cell_cmd_t cmd,
	output logic [pira_pkg::STAT_W-1:0] status_d,
	output logic read_ok,
	output logic [pira_pkg::CNT_W-1:0] count_d,
	output logic [pira_pkg::CNT_W-1:0] count_q
);
	import pira_pkg::*;

	logic [CMP_W-1:0] pos_ext;
	logic [CMP_W-1:0] cnt_ext;
	logic full;

	assign pos_ext = CMP_W'(position);
	assign cnt_ext = CMP_W'(count_q);
	assign full = (cnt_ext == CMP_W'(CAPACITY));

	// Decode the request against the current count.
	always_comb begin
		status_d = ST_RANGE;
		case (func)
			FN_READ: begin
				status_d = (pos_ext >= cnt_ext) ? ST_RANGE : ST_DONE;
			end
			FN_INSERT: begin
				if (pos_ext > cnt_ext) begin
					status_d = ST_RANGE;
				end else if (full) begin
					status_d = ST_FULL;
				end else begin
					status_d = ST_DONE;
				end
			end
			FN_REMOVE: begin
				status_d = (pos_ext >= cnt_ext) ? ST_RANGE : ST_DONE;
			end
			default: begin
				status_d = ST_RANGE;
			end
		endcase
	end

	// Shift command and next count, active only for an accepted, successful transaction.
	always_comb begin
		cmd.pos = pos_ext;
		cmd.ins = accept && (func == FN_INSERT) && (status_d == ST_DONE);
		cmd.rem = accept && (func == FN_REMOVE) && (status_d == ST_DONE);
		read_ok = (func == FN_READ) && (status_d == ST_DONE);
		count_d = count_q;
		if (cmd.ins) begin
			count_d = CNT_W'(count_q + 1'b1);
		end else if (cmd.rem) begin
			count_d = CNT_W'(count_q - 1'b1);
		end
	end

	// Element count register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			count_q <= count_d;
		end
	end

endmodule

/* hw/rtl/positional_insert_remove_array.sv */
// Top level of the positional insert/remove list: controller, row of cells, result register.
// Depends on pira_pkg, pira_ctrl and pira_cell.
//
//  channel | handshake            | payload
//  --------+----------------------+----------------------------------
//  request | req_valid/req_ready  | func, position, value
//  result  | rsp_valid/rsp_ready  | status, read_value, count_after
//
// For every request the whole row of cells shifts, loads or holds in parallel at the
// accepting edge, and the result is captured in the result register at that same edge.
// One request per cycle is sustained while the result side keeps taking transactions.
// Reset clears the element count and the result valid flag; cell contents are left as is.
// A result that is not taken holds the request side off until it leaves.
module positional_insert_remove_array (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	output logic req_ready,
	input logic [pira_pkg::FUNC_W-1:0] func,
	input logic [pira_pkg::POS_W-1:0] position,
	input logic signed [pira_pkg::DATA_W-1:0] value,
	output logic rsp_valid,
	input logic rsp_ready,
	output logic [pira_pkg::STAT_W-1:0] status,
	output logic signed [pira_pkg::DATA_W-1:0] read_value,
	output logic [pira_pkg::POS_W-1:0] count_after
);
	import pira_pkg::*;

	logic accept;
	cell_cmd_t cmd;
	logic [STAT_W-1:0] status_d;
	logic read_ok;
	logic [CNT_W-1:0] count_d;
	logic [CNT_W-1:0] count_q;
	logic [DATA_W-1:0] cell_data [CAPACITY];
	logic [DATA_W-1:0] read_d;
	logic rsp_valid_q;
	logic [STAT_W-1:0] status_q;
	logic [DATA_W-1:0] read_value_q;
	logic [POS_W-1:0] count_after_q;

	// A new transaction is taken whenever the result register is free or draining.
	assign req_ready = !rsp_valid_q || rsp_ready;
	assign accept = req_valid && req_ready;

	pira_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.accept(accept),
		.func(func),
		.position(position),
		.cmd(cmd),
		.status_d(status_d),
		.read_ok(read_ok),
		.count_d(count_d),
		.count_q(count_q)
	);

	// Row of cells; each one sees its two neighbors, the first taking the new value and the last itself at the ends.
	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		logic [DATA_W-1:0] left_data;
		logic [DATA_W-1:0] right_data;

		if (g == 0) begin : g_first
			assign left_data = value;
		end else begin : g_mid_left
			assign left_data = cell_data[g-1];
		end

		if (g == CAPACITY - 1) begin : g_last
			assign right_data = cell_data[g];
		end else begin : g_mid_right
			assign right_data = cell_data[g+1];
		end

		pira_cell u_cell (
			.clk(clk),
			.cmd(cmd),
			.idx(IDX_W'(g)),
			.value(value),
			.left_data(left_data),
			.right_data(right_data),
			.data_q(cell_data[g])
		);
	end

	// Read port: select the cell at the requested position, zero unless the read succeeds.
	always_comb begin
		read_d = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			if (read_ok && (CMP_W'(i) == cmd.pos)) begin
				read_d = cell_data[i];
			end
		end
	end

	// Result valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (accept) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// Result payload register.
	always_ff @(posedge clk) begin
		if (accept) begin
			status_q <= status_d;
			read_value_q <= read_d;
			count_after_q <= POS_W'(count_d);
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign status = status_q;
	assign read_value = read_value_q;
	assign count_after = count_after_q;

	// The count never passes the capacity.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		CMP_W'(count_q) <= CMP_W'(CAPACITY))
		else $error("element count above capacity");

	// An accepted transaction always leaves a result behind.
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> rsp_valid)
		else $error("accepted transaction produced no result");

	// A waiting result blocks the request side.
	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_ready) |-> !req_ready)
		else $error("request taken while result stalled");

	// A rejected transaction leaves the count alone.
	a_reject_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (status_d != ST_DONE)) |=> $stable(count_q))
		else $error("rejected transaction changed the count");

endmodule

/* test/positional_insert_remove_array_tb.sv */
`timescale 1ns / 100ps
// Testbench for positional_insert_remove_array: directed and random read, insert and remove
// requests, each result checked against a behavioral copy of the list kept here.
// Depends on pira_pkg and the positional_insert_remove_array RTL.
module positional_insert_remove_array_tb;
	import pira_pkg::*;

	// Function code with no operation behind it; the block must reject it.
	localparam logic [FUNC_W-1:0] FN_UNDEF = 2'd3;
	localparam int HALF_PERIOD = 6;
	localparam int STALL_LIMIT = 1000;
	localparam int HOLD_CYCLES = 80;
	localparam int SETTLE_CYCLES = 8;
	localparam logic signed [DATA_W-1:0] VAL_MIN = {1'b1, {(DATA_W-1){1'b0}}};
	localparam logic signed [DATA_W-1:0] VAL_MAX = {1'b0, {(DATA_W-1){1'b1}}};

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic signed [DATA_W-1:0] read_value;
		logic [POS_W-1:0] count_after;
	} list_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	logic [FUNC_W-1:0] func = FN_READ;
	logic [POS_W-1:0] position = '0;
	logic signed [DATA_W-1:0] value = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	logic [STAT_W-1:0] status;
	logic signed [DATA_W-1:0] read_value;
	logic [POS_W-1:0] count_after;

	// Shadow copy of the list and the results still owed by the block.
	logic signed [DATA_W-1:0] list_cells [CAPACITY];
	int list_count = 0;
	list_result_t pending_results[$];
	list_result_t oldest_result;

	int error_count = 0;
	int quiet_cycles = 0;
	bit idle_on = 1'b1;
	int hold_asks = 0;
	int hold_seen = 0;
	int stall_left = 0;

	positional_insert_remove_array dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.func(func),
		.position(position),
		.value(value),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.status(status),
		.read_value(read_value),
		.count_after(count_after)
	);

	initial begin
		forever #HALF_PERIOD clk = ~clk;
	end

	// Apply one request to the shadow list and return the result it must produce.
	function automatic list_result_t apply_list_op(input logic [FUNC_W-1:0] f,
			input logic [POS_W-1:0] p, input logic signed [DATA_W-1:0] v);
		list_result_t r;
		int pos;
		pos = p;
		r.status = ST_DONE;
		r.read_value = '0;
		case (f)
			FN_READ: begin
				if (pos >= list_count)
					r.status = ST_RANGE;
				else
					r.read_value = list_cells[pos];
			end
			FN_INSERT: begin
				if (pos > list_count) begin
					r.status = ST_RANGE;
				end else if (list_count >= CAPACITY) begin
					r.status = ST_FULL;
				end else begin
					for (int i = list_count; i > pos; i--)
						list_cells[i] = list_cells[i-1];
					list_cells[pos] = v;
					list_count++;
				end
			end
			FN_REMOVE: begin
				if (pos >= list_count) begin
					r.status = ST_RANGE;
				end else begin
					for (int i = pos; i + 1 < list_count; i++)
						list_cells[i] = list_cells[i+1];
					list_count--;
				end
			end
			default: begin
				r.status = ST_RANGE;
			end
		endcase
		r.count_after = POS_W'(list_count);
		return r;
	endfunction

	// Offer one request, with an occasional gap before it, and record its result once taken.
	task automatic send_request(input logic [FUNC_W-1:0] f, input logic [POS_W-1:0] p,
			input logic signed [DATA_W-1:0] v);
		if (idle_on && $urandom_range(0, 4) == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
		req_valid <= 1'b1;
		func <= f;
		position <= p;
		value <= v;
		do @(posedge clk); while (!req_ready);
		pending_results.push_back(apply_list_op(f, p, v));
	endtask

	function automatic logic signed [DATA_W-1:0] pick_value();
		case ($urandom_range(0, 19))
			0: return VAL_MIN;
			1: return VAL_MAX;
			2: return '0;
			3: return '1;
			default: return $urandom;
		endcase
	endfunction

	// Requests against an empty list, all of which must be rejected, among them an insert past the head.
	task automatic test_empty_list();
		send_request(FN_READ, 5'd0, '0);
		send_request(FN_REMOVE, 5'd0, '0);
		send_request(FN_INSERT, 5'd1, 32'sd5);
		send_request(FN_UNDEF, 5'd0, 32'sd7);
		send_request(FN_READ, 5'd31, '1);
		send_request(FN_REMOVE, 5'd31, '0);
	endtask

	// Extreme values, insert at head, middle and end, reads and removes at every place.
	task automatic test_extremes();
		send_request(FN_INSERT, 5'd0, VAL_MIN);
		send_request(FN_INSERT, 5'd1, VAL_MAX);
		send_request(FN_INSERT, 5'd0, '1);
		send_request(FN_INSERT, 5'd1, '0);
		for (int i = 0; i < 4; i++)
			send_request(FN_READ, POS_W'(i), VAL_MAX);
		send_request(FN_READ, 5'd4, '0);
		send_request(FN_INSERT, 5'd5, 32'sd9);
		send_request(FN_UNDEF, 5'd1, '0);
		send_request(FN_REMOVE, 5'd1, '0);
		send_request(FN_REMOVE, 5'd2, '0);
		send_request(FN_REMOVE, 5'd0, '0);
		send_request(FN_READ, 5'd0, '0);
		send_request(FN_REMOVE, 5'd0, '0);
	endtask

	// Fill the list to capacity, probe the full and range checks, then empty it again.
	task automatic test_full_list();
		while (list_count < CAPACITY)
			send_request(FN_INSERT, POS_W'($urandom_range(0, list_count)), pick_value());
		send_request(FN_INSERT, POS_W'(CAPACITY), 32'sd1);
		send_request(FN_INSERT, 5'd0, 32'sd2);
		send_request(FN_INSERT, POS_W'(CAPACITY + 1), 32'sd3);
		send_request(FN_READ, POS_W'(CAPACITY - 1), '0);
		send_request(FN_READ, POS_W'(CAPACITY), '0);
		send_request(FN_REMOVE, POS_W'(CAPACITY - 1), '0);
		while (list_count > 0)
			send_request(FN_REMOVE, POS_W'($urandom_range(0, list_count - 1)), '0);
	endtask

	// The result side holds off for a long stretch while requests keep coming.
	task automatic test_backpressure();
		hold_asks++;
		for (int i = 0; i < 12; i++)
			send_request(FN_INSERT, POS_W'($urandom_range(0, list_count)), pick_value());
	endtask

	// Mostly well-formed requests that drift between empty and full, with some noise.
	task automatic test_random_traffic(input int n_items, input bit allow_idle);
		logic [FUNC_W-1:0] f;
		logic [POS_W-1:0] p;
		int roll;
		bit grow;
		grow = 1'b1;
		for (int k = 0; k < n_items; k++) begin
			if (k % 64 == 0)
				idle_on = allow_idle && ($urandom_range(0, 2) != 0);
			if (list_count >= CAPACITY)
				grow = 1'b0;
			else if (list_count == 0)
				grow = 1'b1;
			else if ($urandom_range(0, 39) == 0)
				grow = ~grow;
			roll = $urandom_range(0, 99);
			if (roll < 6) begin
				f = FUNC_W'($urandom_range(0, 3));
				p = POS_W'($urandom_range(0, 31));
			end else begin
				roll = $urandom_range(0, 99);
				if (roll < 30)
					f = FN_READ;
				else if (roll < (grow ? 80 : 50))
					f = FN_INSERT;
				else
					f = FN_REMOVE;
				if (f == FN_INSERT)
					p = POS_W'($urandom_range(0, list_count));
				else
					p = (list_count == 0) ? '0 : POS_W'($urandom_range(0, list_count - 1));
			end
			send_request(f, p, pick_value());
		end
	endtask

	// Stimulus sequence, then wait for the last results and report.
	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_list();
		test_extremes();
		test_full_list();
		test_backpressure();
		test_random_traffic(300, 1'b1);
		test_full_list();
		test_random_traffic(250, 1'b1);
		idle_on = 1'b0;
		test_random_traffic(100, 1'b0);
		req_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	// Result side: check each transaction against the oldest expectation and drive ready.
	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_valid && rsp_ready) begin
				if (pending_results.size() == 0) begin
					error_count++;
					$display("%0t: unexpected result: status %0d read_value %0d count_after %0d",
						$time, status, read_value, count_after);
				end else begin
					oldest_result = pending_results.pop_front();
					if ({status, read_value, count_after} !== oldest_result) begin
						error_count++;
						$display({"%0t: mismatch: expected status %0d read_value %0d ",
							"count_after %0d, got status %0d read_value %0d count_after %0d"},
							$time, oldest_result.status, oldest_result.read_value,
							oldest_result.count_after, status, read_value, count_after);
					end
				end
			end
			// A hold-off request from the stimulus starts a long stall here.
			if (hold_seen != hold_asks) begin
				hold_seen = hold_asks;
				stall_left = HOLD_CYCLES;
			end
			if (stall_left > 0) begin
				rsp_ready <= 1'b0;
				stall_left--;
			end else if (idle_on && $urandom_range(0, 5) == 0) begin
				rsp_ready <= 1'b0;
				stall_left = $urandom_range(0, 13);
			end else begin
				rsp_ready <= 1'b1;
			end
		end
	end

	// Watchdog: end the run if no transaction completes on either side for too long.
	always @(posedge clk) begin
		if (arst_n && !(req_valid && req_ready) && !(rsp_valid && rsp_ready))
			quiet_cycles++;
		else
			quiet_cycles = 0;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

endmodule
